// ===== hdl/wpcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wpcd_pkg;

    // Arithmetic sizes
    localparam int SAMPLE_BITS    = 16;
    localparam int STEP_FRAC_BITS = 16;
    localparam int ROW_BITS       = 14;

    // Register and field widths
    localparam int CENTER_W   = 12;
    localparam int SCALE_W    = 13;
    localparam int HEIGHT_W   = 12;
    localparam int STEP_W     = 32;
    localparam int ACC_W      = STEP_W + 1;
    localparam int ORIGIN_W   = 14;
    localparam int COL_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Stream word layout
    localparam int IN_FIELDS_W  = 2 * SAMPLE_BITS + ORIGIN_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = COL_W + 2 * ROW_BITS;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Row arithmetic: center * 2^S - sample * scale, then a truncating shift
    localparam int PROD_W = SAMPLE_BITS + SCALE_W + 1;
    localparam int V_W    = PROD_W + 2;
    localparam int RAW_W  = V_W - SAMPLE_BITS;
    localparam int ROW_HI = (1 << (ROW_BITS - 1)) - 1;
    localparam int ROW_LO = -(1 << (ROW_BITS - 1));

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register reset values
    localparam logic [CENTER_W-1:0] CENTER_RST = '0;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(64);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = '0;
    localparam logic [STEP_W-1:0]   STEP_RST   = STEP_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_ROW       = 3'd0,
        CFG_WAVE_SCALE       = 3'd1,
        CFG_CANVAS_HEIGHT    = 3'd2,
        CFG_FRAMES_PER_PIXEL = 3'd3,
        CFG_SINGLE_SAMPLE    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center_row;
        logic [SCALE_W-1:0]  wave_scale;
        logic [HEIGHT_W-1:0] canvas_height;
        logic [STEP_W-1:0]   frames_per_pixel;
        logic                single_sample_mode;
    } cfg_t;

    // One classified pair, handed from the front to the back
    typedef struct packed {
        logic                   run_start;
        logic                   emit;
        logic                   last;
        logic [SAMPLE_BITS-1:0] col_high;
        logic [SAMPLE_BITS-1:0] col_low;
        logic [SAMPLE_BITS-1:0] fin_high;
        logic [SAMPLE_BITS-1:0] fin_low;
        logic [COL_W-1:0]       col_x;
        logic [COL_W-1:0]       fin_x;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]    column_x;
        logic [ROW_BITS-1:0] row_from;
        logic [ROW_BITS-1:0] row_to;
        logic                is_join;
        logic                last_line;
    } line_t;

endpackage

`default_nettype wire

// ===== hdl/wpcd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wpcd_front import wpcd_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 q_ready,
    output logic                      q_push,
    output cmd_t                      q_cmd
);

    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] peak_high_reg, peak_high_next;
    logic signed [SAMPLE_BITS-1:0] peak_low_reg, peak_low_next;
    logic [COL_W-1:0]              count_reg, count_next;
    logic [ORIGIN_W-1:0]           origin_reg, origin_next;
    logic                          mid_run_reg, mid_run_next;

    logic signed [SAMPLE_BITS-1:0] hs, ls, ph_cur, pl_cur, base_hi, base_lo;
    logic [ORIGIN_W-1:0]           org_in;
    logic [ACC_W-1:0]              acc_cur, acc_sub;
    logic [ACC_W:0]                acc_sum;
    logic [COL_W-1:0]              cnt_cur, org_x;
    logic                          run_start, emit, take;

    assign s_tready = q_ready;
    assign take     = s_tvalid & s_tready;
    assign q_push   = take;

    // Unpack the pair
    assign hs     = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign ls     = $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign org_in = s_tdata[2*SAMPLE_BITS+ORIGIN_W-1:2*SAMPLE_BITS];

    // Classify the pair against the run state
    always_comb
    begin
        run_start = ~mid_run_reg;
        acc_cur   = run_start ? '0 : acc_reg;
        ph_cur    = run_start ? hs : peak_high_reg;
        pl_cur    = run_start ? ls : peak_low_reg;
        cnt_cur   = run_start ? '0 : count_reg;
        origin_next = run_start ? org_in : origin_reg;
        org_x     = {{(COL_W-ORIGIN_W){1'b0}}, origin_next};

        emit    = acc_cur >= {1'b0, cfg.frames_per_pixel};
        acc_sub = emit ? (acc_cur - {1'b0, cfg.frames_per_pixel}) : acc_cur;
        acc_sum = {1'b0, acc_sub} + ((ACC_W+1)'(1) << STEP_FRAC_BITS);
        acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

        base_hi = emit ? hs : ph_cur;
        base_lo = emit ? ls : pl_cur;
        peak_high_next = (hs > base_hi) ? hs : base_hi;
        peak_low_next  = (ls < base_lo) ? ls : base_lo;
        count_next     = emit ? (cnt_cur + 1'b1) : cnt_cur;
        mid_run_next   = ~s_tlast;
    end

    // Build the command word
    always_comb
    begin
        q_cmd.run_start = run_start;
        q_cmd.emit      = emit;
        q_cmd.last      = s_tlast;
        q_cmd.col_high  = ph_cur;
        q_cmd.col_low   = pl_cur;
        q_cmd.fin_high  = peak_high_next;
        q_cmd.fin_low   = peak_low_next;
        q_cmd.col_x     = org_x + cnt_cur;
        q_cmd.fin_x     = org_x + count_next;
    end

    // Advance run state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            peak_high_reg <= '0;
            peak_low_reg  <= '0;
            count_reg     <= '0;
            origin_reg    <= '0;
            mid_run_reg   <= 1'b0;
        end
        else if (take)
        begin
            acc_reg       <= acc_next;
            peak_high_reg <= peak_high_next;
            peak_low_reg  <= peak_low_next;
            count_reg     <= count_next;
            origin_reg    <= origin_next;
            mid_run_reg   <= mid_run_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wpcd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wpcd_queue import wpcd_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      ready,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      pop_cmd
);

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               do_push, do_pop;

    assign ready   = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push & ready;
    assign do_pop  = pop & valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ===== hdl/wpcd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wpcd_back import wpcd_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire logic                  q_valid,
    input  wire cmd_t                  q_cmd,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    // center * 2^S - sample * scale
    function automatic logic signed [V_W-1:0] row_num(
        input logic [SAMPLE_BITS-1:0] s,
        input cfg_t                   c
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [V_W-1:0]    ctr;
        prod = $signed(s) * $signed({1'b0, c.wave_scale});
        ctr  = $signed({{(V_W-CENTER_W-SAMPLE_BITS){1'b0}}, c.center_row,
                        {SAMPLE_BITS{1'b0}}});
        return ctr - {{(V_W-PROD_W){prod[PROD_W-1]}}, prod};
    endfunction

    // Shift right by the sample width, rounding toward zero
    function automatic logic signed [RAW_W-1:0] row_trunc(input logic signed [V_W-1:0] v);
        logic [V_W-1:0]   mag;
        logic [RAW_W-1:0] q;
        mag = v[V_W-1] ? (~v + 1'b1) : v;
        q   = mag[V_W-1:SAMPLE_BITS];
        return v[V_W-1] ? $signed(~q + 1'b1) : $signed(q);
    endfunction

    function automatic logic signed [RAW_W-1:0] row_sat(input logic signed [RAW_W-1:0] y);
        logic signed [RAW_W-1:0] hi, lo;
        hi = RAW_W'(ROW_HI);
        lo = RAW_W'(ROW_LO);
        return (y > hi) ? hi : ((y < lo) ? lo : y);
    endfunction

    function automatic logic signed [RAW_W-1:0] row_clamp(
        input logic signed [RAW_W-1:0] y,
        input cfg_t                    c
    );
        logic signed [RAW_W-1:0] r, lim, hgt;
        hgt = $signed({{(RAW_W-HEIGHT_W){1'b0}}, c.canvas_height});
        lim = $signed({{(RAW_W-CENTER_W){1'b0}}, c.center_row})
            + $signed({{(RAW_W-SCALE_W+1){1'b0}}, c.wave_scale[SCALE_W-1:1]})
            - RAW_W'(1);
        r = y;
        if (r < 0)
            r = '0;
        if (r > hgt)
            r = hgt;
        if (r > lim)
            r = lim;
        return row_sat(r);
    endfunction

    // Product stage
    logic                  a_valid_reg;
    cmd_t                  a_cmd_reg;
    logic signed [V_W-1:0] a_col_hi_reg, a_col_lo_reg, a_fin_hi_reg, a_fin_lo_reg;

    // Row stage
    logic                    b_valid_reg, b_start_reg, b_emit_reg, b_last_reg;
    logic [COL_W-1:0]        b_col_x_reg, b_fin_x_reg;
    logic signed [RAW_W-1:0] b_top_reg, b_bot_reg, b_fin_top_reg, b_fin_bot_reg;

    // Line state and output stage
    logic signed [RAW_W-1:0] prev_top_reg, prev_top_next;
    logic signed [RAW_W-1:0] prev_bot_reg, prev_bot_next;
    logic                    first_reg, first_next;
    line_t                   out_reg, spare_reg;
    logic                    out_valid_reg, spare_valid_reg;

    logic                    ld_ok, b_en, a_en, load;
    logic signed [RAW_W-1:0] ctr_row, pt_eff, pb_eff, t2, b2;
    logic                    first_eff;
    line_t                   col_word, fin_word;

    // Handshake between stages
    assign ld_ok = ~spare_valid_reg & (~out_valid_reg | m_tready);
    assign b_en  = ~b_valid_reg | ld_ok;
    assign a_en  = ~a_valid_reg | b_en;
    assign q_pop = a_en & q_valid;
    assign load  = b_valid_reg & ld_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
                a_valid_reg <= q_valid;
            if (b_en)
                b_valid_reg <= a_valid_reg;
        end
    end

    // Multiply samples by the scale
    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_cmd_reg    <= q_cmd;
            a_col_hi_reg <= row_num(q_cmd.col_high, cfg);
            a_col_lo_reg <= row_num(q_cmd.col_low, cfg);
            a_fin_hi_reg <= row_num(q_cmd.fin_high, cfg);
            a_fin_lo_reg <= row_num(q_cmd.fin_low, cfg);
        end
    end

    // Truncate rows; clamp the column rows and saturate the final rows
    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            b_start_reg   <= a_cmd_reg.run_start;
            b_emit_reg    <= a_cmd_reg.emit;
            b_last_reg    <= a_cmd_reg.last;
            b_col_x_reg   <= a_cmd_reg.col_x;
            b_fin_x_reg   <= a_cmd_reg.fin_x;
            b_top_reg     <= row_clamp(row_trunc(a_col_hi_reg), cfg);
            b_bot_reg     <= row_clamp(row_trunc(a_col_lo_reg), cfg);
            b_fin_top_reg <= row_sat(row_trunc(a_fin_hi_reg));
            b_fin_bot_reg <= row_sat(row_trunc(a_fin_lo_reg));
        end
    end

    // Join against the previous column and form the lines
    always_comb
    begin
        ctr_row   = $signed({{(RAW_W-CENTER_W){1'b0}}, cfg.center_row});
        pt_eff    = b_start_reg ? ctr_row : prev_top_reg;
        pb_eff    = b_start_reg ? ctr_row : prev_bot_reg;
        first_eff = b_start_reg | first_reg;

        t2 = b_top_reg;
        b2 = b_bot_reg;
        if (!first_eff && (b_top_reg > pb_eff))
            t2 = pb_eff + RAW_W'(1);
        if (!first_eff && (b_bot_reg < pt_eff))
            b2 = pt_eff - RAW_W'(1);

        col_word.column_x  = b_col_x_reg;
        col_word.last_line = 1'b0;
        if (cfg.single_sample_mode)
        begin
            col_word.row_from = pt_eff[ROW_BITS-1:0];
            col_word.row_to   = b_top_reg[ROW_BITS-1:0];
            col_word.is_join  = 1'b1;
        end
        else
        begin
            col_word.row_from = t2[ROW_BITS-1:0];
            col_word.row_to   = b2[ROW_BITS-1:0];
            col_word.is_join  = 1'b0;
        end

        fin_word.column_x  = b_fin_x_reg;
        fin_word.row_from  = b_fin_top_reg[ROW_BITS-1:0];
        fin_word.row_to    = b_fin_bot_reg[ROW_BITS-1:0];
        fin_word.is_join   = 1'b0;
        fin_word.last_line = 1'b1;

        prev_top_next = b_emit_reg ? b_top_reg : pt_eff;
        prev_bot_next = b_emit_reg ? b_bot_reg : pb_eff;
        if (b_emit_reg)
            first_next = cfg.single_sample_mode ? first_eff : 1'b0;
        else
            first_next = first_eff;
    end

    // Hold line state across columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_top_reg <= $signed({{(RAW_W-CENTER_W){1'b0}}, CENTER_RST});
            prev_bot_reg <= $signed({{(RAW_W-CENTER_W){1'b0}}, CENTER_RST});
            first_reg    <= 1'b1;
        end
        else if (load)
        begin
            prev_top_reg <= prev_top_next;
            prev_bot_reg <= prev_bot_next;
            first_reg    <= first_next;
        end
    end

    // Output register with one spare line behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg   <= b_emit_reg | b_last_reg;
            spare_valid_reg <= b_emit_reg & b_last_reg;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_reg   <= spare_valid_reg;
            spare_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg   <= b_emit_reg ? col_word : fin_word;
            spare_reg <= fin_word;
        end
        else if (out_valid_reg && m_tready && spare_valid_reg)
        begin
            out_reg <= spare_reg;
        end
    end

    // Drive the master port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_reg.row_to,
                       out_reg.row_from, out_reg.column_x};
    assign m_tuser  = out_reg.is_join;
    assign m_tlast  = out_reg.last_line;

endmodule

`default_nettype wire

// ===== hdl/waveform_peak_column_drawer_core.sv =====
// An accepted pair passes the command queue, product stage and row stage into the
// output register. Throughput: one pair per cycle while the queue has room; a
// pair that closes a column and also ends the run yields two lines, which leave
// the single output port in turn, absorbed by the four-entry command queue.
// Reset: registers take their default values, the run state clears, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module waveform_peak_column_drawer_core import wpcd_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // slave stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // high_sample, low_sample, column_origin
    input  wire logic                  s_tlast,   // last_pair
    // master stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // column_x, row_from, row_to
    output logic                       m_tuser,   // is_join
    output logic                       m_tlast    // last_line
);

    logic [CENTER_W-1:0] center_row_reg;
    logic [SCALE_W-1:0]  wave_scale_reg;
    logic [HEIGHT_W-1:0] canvas_height_reg;
    logic [STEP_W-1:0]   frames_per_pixel_reg;
    logic                single_sample_reg;
    cfg_t                cfg;

    logic q_push, q_ready, q_pop, q_valid;
    cmd_t push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_row_reg       <= CENTER_RST;
            wave_scale_reg       <= SCALE_RST;
            canvas_height_reg    <= HEIGHT_RST;
            frames_per_pixel_reg <= STEP_RST;
            single_sample_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CENTER_ROW:       center_row_reg       <= cfg_data[CENTER_W-1:0];
                CFG_WAVE_SCALE:       wave_scale_reg       <= cfg_data[SCALE_W-1:0];
                CFG_CANVAS_HEIGHT:    canvas_height_reg    <= cfg_data[HEIGHT_W-1:0];
                CFG_FRAMES_PER_PIXEL: frames_per_pixel_reg <= cfg_data[STEP_W-1:0];
                CFG_SINGLE_SAMPLE:    single_sample_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.center_row         = center_row_reg;
        cfg.wave_scale         = wave_scale_reg;
        cfg.canvas_height      = canvas_height_reg;
        cfg.frames_per_pixel   = frames_per_pixel_reg;
        cfg.single_sample_mode = single_sample_reg;
    end

    wpcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    wpcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    wpcd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The run-ending line is always a vertical line
    a_last_not_join: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tuser)
        else $error("final line flagged as join");

    // The front never pushes into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("command pushed into full queue");

    // The back never pops an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");

endmodule

`default_nettype wire

// ===== dv/tb_waveform_peak_column_drawer_core.sv =====
`timescale 1ns / 1ps

module tb_waveform_peak_column_drawer_core;
    import wpcd_pkg::*;

    localparam int          HOLD_CYCLES = 300;
    localparam int          STALL_LIMIT = 4000;
    localparam int          SETTLE_GAP  = 12;
    localparam int          PHASES      = 12;
    localparam int          PHASE_ITEMS = 146;
    localparam int          SHOW_MAX    = 10;
    localparam longint      ROW_UNIT    = longint'(1) << SAMPLE_BITS;
    localparam longint      ACC_STEP    = longint'(1) << STEP_FRAC_BITS;
    localparam longint unsigned ACC_MAX = (64'd1 << ACC_W) - 1;

    // Predicts the column lines of each accepted pair and checks the output stream
    class line_scoreboard;
        logic [CENTER_W-1:0] center;
        logic [SCALE_W-1:0]  scale;
        logic [HEIGHT_W-1:0] height;
        logic [STEP_W-1:0]   step;
        logic                single;

        longint unsigned     acc;
        longint              pk_hi;
        longint              pk_lo;
        longint              prev_top;
        longint              prev_bot;
        logic [COL_W-1:0]    col_count;
        logic [ORIGIN_W-1:0] origin;
        logic                first_col;
        logic                in_run;

        line_t               lines_due[$];
        int                  errors;

        function new();
            center    = CENTER_RST;
            scale     = SCALE_RST;
            height    = HEIGHT_RST;
            step      = STEP_RST;
            single    = 1'b0;
            acc       = 0;
            pk_hi     = 0;
            pk_lo     = 0;
            prev_top  = 0;
            prev_bot  = 0;
            col_count = '0;
            origin    = '0;
            first_col = 1'b1;
            in_run    = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_CENTER_ROW:       center = d[CENTER_W-1:0];
                CFG_WAVE_SCALE:       scale  = d[SCALE_W-1:0];
                CFG_CANVAS_HEIGHT:    height = d[HEIGHT_W-1:0];
                CFG_FRAMES_PER_PIXEL: step   = d[STEP_W-1:0];
                CFG_SINGLE_SAMPLE:    single = d[0];
                default: ;
            endcase
        endfunction

        // center - sample * scale / 2^S, truncated toward zero
        function longint row_of(longint s);
            longint v;
            v = longint'(center) * ROW_UNIT - s * longint'(scale);
            return v / ROW_UNIT;
        endfunction

        function longint sat_row(longint y);
            if (y > ROW_HI)
                return ROW_HI;
            if (y < ROW_LO)
                return ROW_LO;
            return y;
        endfunction

        function longint clamp_row(longint y);
            longint lim;
            lim = longint'(center) + longint'(scale / 2) - 1;
            if (y < 0)
                y = 0;
            if (y > longint'(height))
                y = longint'(height);
            if (y > lim)
                y = lim;
            return sat_row(y);
        endfunction

        function void add_line(longint from_row, longint to_row, logic diag, logic fin);
            line_t l;
            l.column_x  = COL_W'(origin + col_count);
            l.row_from  = from_row[ROW_BITS-1:0];
            l.row_to    = to_row[ROW_BITS-1:0];
            l.is_join   = diag;
            l.last_line = fin;
            lines_due.insert(lines_due.size(), l);
        endfunction

        function void predict_lines(logic signed [SAMPLE_BITS-1:0] hs_in,
                                    logic signed [SAMPLE_BITS-1:0] ls_in,
                                    logic [ORIGIN_W-1:0] org, logic last_in);
            longint hs;
            longint ls;
            longint top;
            longint bot;
            longint top_adj;
            longint bot_adj;
            hs = hs_in;
            ls = ls_in;
            // Open a run on the first pair
            if (!in_run)
            begin
                in_run    = 1'b1;
                acc       = 0;
                col_count = '0;
                first_col = 1'b1;
                pk_hi     = hs;
                pk_lo     = ls;
                prev_top  = longint'(center);
                prev_bot  = longint'(center);
                origin    = org;
            end
            // Close the pending column once the step is reached
            if (acc >= longint'(step))
            begin
                top = clamp_row(row_of(pk_hi));
                bot = clamp_row(row_of(pk_lo));
                if (single)
                    add_line(prev_top, top, 1'b1, 1'b0);
                else
                begin
                    top_adj = top;
                    bot_adj = bot;
                    // Stretch a column that does not reach the previous one
                    if (!first_col)
                    begin
                        if (top_adj > prev_bot)
                            top_adj = prev_bot + 1;
                        if (bot_adj < prev_top)
                            bot_adj = prev_top - 1;
                    end
                    else
                        first_col = 1'b0;
                    add_line(top_adj, bot_adj, 1'b0, 1'b0);
                end
                acc       = acc - longint'(step);
                col_count = col_count + 1'b1;
                prev_top  = top;
                prev_bot  = bot;
                pk_hi     = hs;
                pk_lo     = ls;
            end
            acc = acc + ACC_STEP;
            if (acc > ACC_MAX)
                acc = ACC_MAX;
            if (hs > pk_hi)
                pk_hi = hs;
            if (ls < pk_lo)
                pk_lo = ls;
            // Final column of the run, rows left unclamped
            if (last_in)
            begin
                add_line(sat_row(row_of(pk_hi)), sat_row(row_of(pk_lo)), 1'b0, 1'b1);
                in_run = 1'b0;
            end
        endfunction

        function void check_line(line_t got);
            line_t want;
            if (lines_due.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("unexpected line: column_x %0d row_from %0d row_to %0d join %0b last %0b",
                             got.column_x, $signed(got.row_from), $signed(got.row_to),
                             got.is_join, got.last_line);
                return;
            end
            want = lines_due.pop_front();
            if (got.column_x !== want.column_x || got.row_from !== want.row_from ||
                got.row_to !== want.row_to || got.is_join !== want.is_join ||
                got.last_line !== want.last_line)
            begin
                errors++;
                if (errors <= SHOW_MAX)
                begin
                    $display("line mismatch: column_x exp %0d got %0d, row_from exp %0d got %0d",
                             want.column_x, got.column_x,
                             $signed(want.row_from), $signed(got.row_from));
                    $display("  row_to exp %0d got %0d, join exp %0b got %0b, last exp %0b got %0b",
                             $signed(want.row_to), $signed(got.row_to),
                             want.is_join, got.is_join, want.last_line, got.last_line);
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // high_sample, low_sample, column_origin
    logic                  s_tlast   = 1'b0; // last_pair
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // column_x, row_from, row_to
    logic                  m_tuser;          // is_join
    logic                  m_tlast;          // last_line

    line_scoreboard sb = new();

    int send_idle  = 0;
    int recv_stall = 0;
    int hold_req   = 0;
    int hold_left  = 0;
    int stall_cnt  = 0;
    int run_left   = 0;

    waveform_peak_column_drawer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drive the receiver ready; a requested hold-off drops it for a long stretch
    always
    begin
        @(negedge clk);
        if (hold_req != 0)
        begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Check every accepted line word
    always @(posedge clk)
    begin
        line_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.column_x  = m_tdata[COL_W-1:0];
            got.row_from  = m_tdata[COL_W +: ROW_BITS];
            got.row_to    = m_tdata[COL_W+ROW_BITS +: ROW_BITS];
            got.is_join   = m_tuser;
            got.last_line = m_tlast;
            sb.check_line(got);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt == STALL_LIMIT)
        begin
            $display("tb_waveform_peak_column_drawer_core NOT OK");
            $finish;
        end
    end

    task automatic send_pair(logic signed [SAMPLE_BITS-1:0] hs,
                             logic signed [SAMPLE_BITS-1:0] ls,
                             logic [ORIGIN_W-1:0] org, logic last_in);
        while ($urandom_range(99) < send_idle)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({org, ls, hs});
        s_tlast  <= last_in;
        do
            @(posedge clk);
        while (!s_tready);
        sb.predict_lines(hs, ls, org, last_in);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, d);
    endtask

    task automatic set_regs(int unsigned c, int unsigned s, int unsigned h,
                            logic [STEP_W-1:0] f, logic m);
        write_reg(CFG_CENTER_ROW, c);
        write_reg(CFG_WAVE_SCALE, s);
        write_reg(CFG_CANVAS_HEIGHT, h);
        write_reg(CFG_FRAMES_PER_PIXEL, f);
        write_reg(CFG_SINGLE_SAMPLE, CFG_DATA_W'(m));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every expected line, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.lines_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    function automatic int unsigned pick_range(int unsigned lo, int unsigned hi);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 35)
            return STEP_W'(65536);
        if (r < 85)
            return STEP_W'($urandom_range(32'h40000, 1));
        return STEP_W'($urandom);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            4, 5:    return SAMPLE_BITS'(int'($urandom_range(400)) - 200);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // One random pair; runs carry on across phase boundaries
    task automatic send_random();
        int unsigned r;
        if (run_left == 0)
        begin
            r = $urandom_range(99);
            if (r < 5)
                run_left = 1;
            else if (r < 75)
                run_left = $urandom_range(16, 1);
            else
                run_left = $urandom_range(60, 17);
        end
        send_pair(pick_sample(), pick_sample(), ORIGIN_W'(pick_range(0, 16383)),
                  run_left == 1);
        run_left--;
    endtask

    initial
    begin
        int p;
        int i;

        // Reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Normal mode: single-pair run, first column, stretched columns, double result
        set_regs(2048, 4096, 4095, STEP_W'(65536), 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 14'd0, 1'b1);
        send_pair(16'sd100, -16'sd100, 14'd16383, 1'b0);
        send_pair(16'sh7fff, 16'sd30000, 14'd0, 1'b0);
        send_pair(16'sh8000, -16'sd30000, 14'd0, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff, 14'd0, 1'b0);
        send_pair(16'sd0, 16'sd0, 14'd0, 1'b1);
        drain();

        // Diagonal joins, zero step closes a column on every pair
        set_regs(0, 1, 0, '0, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 14'd5, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 14'd0, 1'b0);
        send_pair(-16'sd1, 16'sd0, 14'd0, 1'b0);
        send_pair(16'sd1234, -16'sd1234, 14'd0, 1'b1);
        drain();

        // Step never reached: final lines only
        set_regs(4095, 4096, 100, '1, 1'b0);
        send_pair(16'sh8000, 16'sh8000, 14'd8000, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 14'd0, 1'b0);
        send_pair(16'sd0, 16'sd0, 14'd0, 1'b1);
        drain();

        // Fractional step with joins
        set_regs(300, 2048, 250, STEP_W'(98304), 1'b1);
        send_pair(16'sd9000, -16'sd9000, 14'd1, 1'b0);
        send_pair(16'sh7fff, 16'sd0, 14'd0, 1'b0);
        send_pair(-16'sd20000, 16'sh8000, 14'd0, 1'b0);
        send_pair(16'sd4, 16'sd3, 14'd0, 1'b0);
        send_pair(16'sd0, 16'sh8000, 14'd0, 1'b0);
        send_pair(16'sd500, -16'sd500, 14'd0, 1'b1);
        drain();

        // Random phases, cycling through the idle patterns
        for (p = 0; p < PHASES; p++)
        begin
            set_regs(pick_range(0, 4095), pick_range(1, 4096), pick_range(0, 4095),
                     pick_step(), 1'($urandom_range(1)));
            case (p % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 69; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 69; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // Back up the output while pairs keep coming
                if (p == 4 && i == 10)
                    hold_req = 1;
                // Pause the sender until the block is empty
                if (p == 9 && i == PHASE_ITEMS / 2)
                    drain();
                send_random();
            end
            drain();
        end

        repeat (SETTLE_GAP) @(posedge clk);
        if (sb.errors == 0 && sb.lines_due.size() == 0)
            $display("tb_waveform_peak_column_drawer_core OK");
        else
            $display("tb_waveform_peak_column_drawer_core NOT OK");
        $finish;
    end

endmodule
